[rtl/imh_pkg.sv]
package imh_pkg;

  localparam int CAPACITY_DEF     = 64;
  localparam int ID_BITS_DEF      = 8;
  localparam int KEY_BITS_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int REQ_BITS    = 3;
  localparam int STATUS_BITS = 3;
  localparam int LIMIT_BITS  = 7;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_UPDATE  = 3'd1,
    REQ_DELETE  = 3'd2,
    REQ_READ    = 3'd3,
    REQ_EXTRACT = 3'd4,
    REQ_GET_KEY = 3'd5,
    REQ_CLEAR   = 3'd6
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_INVALID = 3'd3,
    ST_BUSY    = 3'd4
  } status_t;

endpackage

[rtl/indexed_min_heap_unit.sv]
// Indexed binary min-heap priority queue.
// Slave channel s_axis_*: one request per beat (insert, update key, delete,
// read min, extract min, get key, clear). Master channel m_axis_*: exactly
// one result beat per request, carrying status, handle, key and payload.
// cfg_we/cfg_data write capacity_limit (reset 64); write only while idle.
// Requests are processed one at a time; s_axis_tready is low while busy.
// Heap slots live in one memory with a registered read port, and the sifted
// entry rides in a register while the hole moves: read and compare the parent
// per level up, read the children and compare per level down, plus a final
// writeback of the entry. Read min, clear and errors answer after the lookup;
// get key adds a fetch of the target slot; insert adds the sift, and update,
// delete and extract add the fetch and, where needed, the sift.
// The handle-to-slot map is a second memory; its presence bits are
// flip-flops cleared all at once by reset and by a clear request.
// A result waits in the output register while m_axis_tready is low; the
// next request is taken in the cycle after that beat is delivered.
// Reset: heap empty, next handle zero, all presence bits clear.
module indexed_min_heap_unit #(
  parameter int CAPACITY     = imh_pkg::CAPACITY_DEF,
  parameter int ID_BITS      = imh_pkg::ID_BITS_DEF,
  parameter int KEY_BITS     = imh_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = imh_pkg::PAYLOAD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [imh_pkg::LIMIT_BITS-1:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // req_type[2:0], key, payload, item_id (lowest first), zero padded
  input  logic [((3+KEY_BITS+PAYLOAD_BITS+ID_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status[2:0], result_id, result_key, result_payload (lowest first)
  output logic [((3+KEY_BITS+PAYLOAD_BITS+ID_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int PB = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CB = $clog2(CAPACITY + 1);
  localparam int NH = 1 << ID_BITS;
  localparam int SW = PB + 2;

  typedef logic [PB-1:0] pos_t;
  typedef logic [SW-1:0] spos_t;
  typedef struct packed {
    logic [KEY_BITS-1:0]     k;
    logic [PAYLOAD_BITS-1:0] p;
    logic [ID_BITS-1:0]      h;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_FETCH, S_GOT, S_LAST, S_LGOT, S_RDP, S_CMPP, S_RDL, S_RDR,
    S_CMPC, S_WB2, S_RES
  } state_t;

  state_t state;
  ent_t heap_mem [CAPACITY];
  logic [PB-1:0] pos_mem [NH];
  logic [NH-1:0] present;
  ent_t rd_ent;
  pos_t rd_pos;

  logic [CB-1:0] count;
  logic [ID_BITS-1:0] next_h;
  logic [imh_pkg::LIMIT_BITS-1:0] limit;
  logic [2:0] req;
  logic [KEY_BITS-1:0] rkey;
  logic [PAYLOAD_BITS-1:0] rpay;
  logic [ID_BITS-1:0] rhid;
  ent_t cur;      // entry being sifted
  pos_t cpos;     // hole it currently sits over
  ent_t lch;
  logic down;     // removal: fall back to sift down if the first up step fails
  logic [2:0] st;
  logic [ID_BITS-1:0] oid;
  logic [KEY_BITS-1:0] okey;
  logic [PAYLOAD_BITS-1:0] opay;

  // memory port control
  logic ra_en;
  pos_t ra;
  logic wa_en;
  pos_t wa;
  ent_t wd;
  logic pw_en;
  logic [ID_BITS-1:0] pw_a;
  pos_t pw_d;
  logic [ID_BITS-1:0] pr_a;

  always_ff @(posedge clk) begin
    if (ra_en) rd_ent <= heap_mem[ra];
    if (wa_en) heap_mem[wa] <= wd;
    rd_pos <= pos_mem[pr_a];
    if (pw_en) pos_mem[pw_a] <= pw_d;
  end

  logic [CB-1:0] lim_eff;
  always_comb begin
    if ({{(32-imh_pkg::LIMIT_BITS){1'b0}}, limit} > CAPACITY) lim_eff = CB'(CAPACITY);
    else lim_eff = CB'(limit);
  end

  spos_t lidx, ridx;
  assign lidx = spos_t'({cpos, 1'b1});
  assign ridx = spos_t'({cpos, 1'b0}) + spos_t'(2);
  logic lv, rv;
  assign lv = lidx < spos_t'(count);
  assign rv = ridx < spos_t'(count);
  pos_t ppos;
  assign ppos = pos_t'((spos_t'(cpos) - spos_t'(1)) >> 1);

  // pick the smaller child, left on ties; move only if strictly below cur
  logic l_lt, r_lt, c_move;
  ent_t c_ent;
  pos_t c_pos;
  assign l_lt = lch.k < cur.k;
  assign r_lt = rv && (rd_ent.k < (l_lt ? lch.k : cur.k));
  assign c_move = l_lt || r_lt;
  assign c_ent = r_lt ? rd_ent : lch;
  assign c_pos = r_lt ? pos_t'(ridx) : pos_t'(lidx);

  logic [2:0] in_req;
  assign in_req = s_axis_tdata[2:0];
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    ra_en = 1'b0; ra = cpos;
    wa_en = 1'b0; wa = cpos; wd = cur;
    pw_en = 1'b0; pw_a = cur.h; pw_d = cpos;
    pr_a = s_axis_tdata[3+KEY_BITS+PAYLOAD_BITS +: ID_BITS];
    unique case (state)
      S_IDLE: begin
        ra_en = 1'b1; ra = '0;
      end
      S_FETCH: begin
        ra_en = 1'b1;
      end
      S_LAST: begin
        ra_en = 1'b1; ra = pos_t'(count);
      end
      S_RDP: begin
        if (cpos != '0) begin
          ra_en = 1'b1; ra = ppos;
        end
      end
      S_CMPP: begin
        // pull the parent down into the hole
        if (cur.k < rd_ent.k) begin
          wa_en = 1'b1; wd = rd_ent;
          pw_en = 1'b1; pw_a = rd_ent.h;
        end
      end
      S_RDL: begin
        if (lv) begin
          ra_en = 1'b1; ra = pos_t'(lidx);
        end
      end
      S_RDR: begin
        if (rv) begin
          ra_en = 1'b1; ra = pos_t'(ridx);
        end
      end
      S_CMPC: begin
        // lift the chosen child into the hole
        if (c_move) begin
          wa_en = 1'b1; wd = c_ent;
          pw_en = 1'b1; pw_a = c_ent.h;
        end
      end
      S_WB2: begin
        wa_en = 1'b1;
        pw_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      next_h <= '0;
      limit <= imh_pkg::LIMIT_BITS'(64);
      present <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (state == S_RES) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            req <= in_req;
            rkey <= s_axis_tdata[3 +: KEY_BITS];
            rpay <= s_axis_tdata[3+KEY_BITS +: PAYLOAD_BITS];
            rhid <= s_axis_tdata[3+KEY_BITS+PAYLOAD_BITS +: ID_BITS];
            st <= imh_pkg::ST_OK;
            oid <= '0; okey <= '0; opay <= '0;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          // rd_ent = slot 0, rd_pos = slot of handle
          state <= S_RES;
          down <= 1'b0;
          case (req)
            imh_pkg::REQ_INSERT: begin
              if (count >= lim_eff) st <= imh_pkg::ST_FULL;
              else if (present[next_h]) st <= imh_pkg::ST_BUSY;
              else begin
                cur <= '{k: rkey, p: rpay, h: next_h};
                cpos <= pos_t'(count);
                present[next_h] <= 1'b1;
                count <= count + CB'(1);
                oid <= next_h;
                next_h <= next_h + ID_BITS'(1);
                state <= S_RDP;
              end
            end
            imh_pkg::REQ_UPDATE: begin
              if (!present[rhid]) st <= imh_pkg::ST_INVALID;
              else begin
                cpos <= rd_pos;
                state <= S_FETCH;
              end
            end
            imh_pkg::REQ_DELETE, imh_pkg::REQ_GET_KEY: begin
              if (count == '0) st <= imh_pkg::ST_EMPTY;
              else if (!present[rhid]) st <= imh_pkg::ST_INVALID;
              else begin
                cpos <= rd_pos;
                state <= S_FETCH;
              end
            end
            imh_pkg::REQ_READ, imh_pkg::REQ_EXTRACT: begin
              if (count == '0) st <= imh_pkg::ST_EMPTY;
              else begin
                oid <= rd_ent.h; okey <= rd_ent.k; opay <= rd_ent.p;
                if (req == imh_pkg::REQ_EXTRACT) begin
                  cpos <= '0;
                  state <= S_FETCH;
                end
              end
            end
            imh_pkg::REQ_CLEAR: begin
              present <= '0; count <= '0; next_h <= '0;
            end
            default: ;
          endcase
        end
        S_FETCH: begin
          state <= S_GOT;
        end
        S_GOT: begin
          // rd_ent = target slot
          state <= S_RES;
          case (req)
            imh_pkg::REQ_GET_KEY: okey <= rd_ent.k;
            imh_pkg::REQ_UPDATE: begin
              cur <= '{k: rkey, p: rd_ent.p, h: rd_ent.h};
              if (rkey < rd_ent.k) state <= S_RDP;
              else if (rkey > rd_ent.k) state <= S_RDL;
            end
            default: begin
              // delete / extract: free target handle, then pull in last slot
              present[rd_ent.h] <= 1'b0;
              count <= count - CB'(1);
              if (CB'(cpos) != count - CB'(1)) state <= S_LAST;
            end
          endcase
        end
        S_LAST: begin
          state <= S_LGOT;
        end
        S_LGOT: begin
          cur <= rd_ent;
          down <= 1'b1;
          state <= S_RDP;
        end
        S_RDP: begin
          if (cpos == '0) state <= down ? S_RDL : S_WB2;
          else state <= S_CMPP;
        end
        S_CMPP: begin
          if (cur.k < rd_ent.k) begin
            cpos <= ppos;
            down <= 1'b0;
            state <= S_RDP;
          end else if (down) begin
            down <= 1'b0;
            state <= S_RDL;
          end else state <= S_WB2;
        end
        S_RDL: begin
          state <= lv ? S_RDR : S_WB2;
        end
        S_RDR: begin
          // rd_ent = left child
          lch <= rd_ent;
          state <= S_CMPC;
        end
        S_CMPC: begin
          if (c_move) begin
            cpos <= c_pos;
            state <= S_RDL;
          end else state <= S_WB2;
        end
        S_WB2: begin
          state <= S_RES;
        end
        S_RES: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[2:0] = st;
    m_axis_tdata[3 +: ID_BITS] = oid;
    m_axis_tdata[3+ID_BITS +: KEY_BITS] = okey;
    m_axis_tdata[3+ID_BITS+KEY_BITS +: PAYLOAD_BITS] = opay;
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(CAPACITY)) else $error("count above capacity");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_res: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES) |=> m_axis_tvalid) else $error("result lost");

endmodule

[tb/imh_heap_checker.sv]
`timescale 1ns / 1ps

module imh_heap_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  output int           fails,
  output int           pending
);

  typedef struct {
    imh_pkg::status_t st;
    logic [7:0]  id;
    logic [63:0] k;
    logic [31:0] p;
  } heap_reply_t;

  logic [63:0] slot_key[64];
  logic [31:0] slot_pay[64];
  logic [7:0]  slot_hdl[64];
  int          hdl_slot[256];
  bit          hdl_live[256];
  int          live_cnt;
  logic [7:0]  next_hdl;
  logic [6:0]  cap_lim;
  heap_reply_t reply_q[$];

  function automatic void swap_slots(int a, int b);
    logic [63:0] k;
    logic [31:0] p;
    logic [7:0]  h;
    k = slot_key[a]; p = slot_pay[a]; h = slot_hdl[a];
    slot_key[a] = slot_key[b]; slot_pay[a] = slot_pay[b]; slot_hdl[a] = slot_hdl[b];
    slot_key[b] = k; slot_pay[b] = p; slot_hdl[b] = h;
    hdl_slot[slot_hdl[a]] = a;
    hdl_slot[slot_hdl[b]] = b;
  endfunction

  function automatic void raise_slot(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (slot_key[pos] >= slot_key[up]) break;
      swap_slots(pos, up);
      pos = up;
    end
  endfunction

  // ties stay put; left child wins when both children are equal
  function automatic void lower_slot(int pos);
    int l, r, best;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      best = pos;
      if (l < live_cnt && slot_key[l] < slot_key[best]) best = l;
      if (r < live_cnt && slot_key[r] < slot_key[best]) best = r;
      if (best == pos) break;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic void drop_slot(int pos);
    int last;
    last = live_cnt - 1;
    if (pos != last) swap_slots(pos, last);
    hdl_live[slot_hdl[last]] = 1'b0;
    live_cnt = last;
    if (pos < live_cnt) begin
      if (pos > 0 && slot_key[pos] < slot_key[(pos - 1) / 2]) raise_slot(pos);
      else lower_slot(pos);
    end
  endfunction

  function automatic heap_reply_t apply_request(logic [111:0] d);
    heap_reply_t rp;
    logic [2:0]  req;
    logic [63:0] key;
    logic [31:0] pay;
    logic [7:0]  hid;
    logic [63:0] old;
    int          lim;
    int          pos;
    req = d[2:0];
    key = d[66:3];
    pay = d[98:67];
    hid = d[106:99];
    rp = '{imh_pkg::ST_OK, 8'd0, 64'd0, 32'd0};
    lim = (cap_lim < 64) ? cap_lim : 64;
    case (req)
      imh_pkg::REQ_INSERT: begin
        if (live_cnt >= lim) rp.st = imh_pkg::ST_FULL;
        else if (hdl_live[next_hdl]) rp.st = imh_pkg::ST_BUSY;
        else begin
          pos = live_cnt;
          slot_key[pos] = key;
          slot_pay[pos] = pay;
          slot_hdl[pos] = next_hdl;
          hdl_slot[next_hdl] = pos;
          hdl_live[next_hdl] = 1'b1;
          live_cnt = pos + 1;
          rp.id = next_hdl;
          next_hdl = next_hdl + 8'd1;
          raise_slot(pos);
        end
      end
      imh_pkg::REQ_UPDATE: begin
        if (!hdl_live[hid]) rp.st = imh_pkg::ST_INVALID;
        else begin
          pos = hdl_slot[hid];
          old = slot_key[pos];
          slot_key[pos] = key;
          if (key < old) raise_slot(pos);
          else if (key > old) lower_slot(pos);
        end
      end
      imh_pkg::REQ_DELETE: begin
        if (live_cnt == 0) rp.st = imh_pkg::ST_EMPTY;
        else if (!hdl_live[hid]) rp.st = imh_pkg::ST_INVALID;
        else drop_slot(hdl_slot[hid]);
      end
      imh_pkg::REQ_READ, imh_pkg::REQ_EXTRACT: begin
        if (live_cnt == 0) rp.st = imh_pkg::ST_EMPTY;
        else begin
          rp.id = slot_hdl[0];
          rp.k = slot_key[0];
          rp.p = slot_pay[0];
          if (req == imh_pkg::REQ_EXTRACT) drop_slot(0);
        end
      end
      imh_pkg::REQ_GET_KEY: begin
        if (live_cnt == 0) rp.st = imh_pkg::ST_EMPTY;
        else if (!hdl_live[hid]) rp.st = imh_pkg::ST_INVALID;
        else rp.k = slot_key[hdl_slot[hid]];
      end
      imh_pkg::REQ_CLEAR: begin
        foreach (hdl_live[i]) hdl_live[i] = 1'b0;
        live_cnt = 0;
        next_hdl = 8'd0;
      end
      default: ;
    endcase
    return rp;
  endfunction

  always @(posedge clk) begin
    heap_reply_t want;
    if (rst) begin
      foreach (hdl_live[i]) hdl_live[i] = 1'b0;
      live_cnt = 0;
      next_hdl = 8'd0;
      cap_lim = 7'd64;
      reply_q.delete();
    end else begin
      if (cfg_we) cap_lim = cfg_data;
      if (s_axis_tvalid && s_axis_tready)
        reply_q.insert(reply_q.size(), apply_request(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h", $time, m_axis_tdata);
          fails = fails + 1;
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata[2:0] !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tdata[2:0]);
            fails = fails + 1;
          end
          if (m_axis_tdata[10:3] !== want.id) begin
            $display("%0t: result_id expected %0d actual %0d", $time, want.id,
                     m_axis_tdata[10:3]);
            fails = fails + 1;
          end
          if (m_axis_tdata[74:11] !== want.k) begin
            $display("%0t: result_key expected %h actual %h", $time, want.k,
                     m_axis_tdata[74:11]);
            fails = fails + 1;
          end
          if (m_axis_tdata[106:75] !== want.p) begin
            $display("%0t: result_payload expected %h actual %h", $time, want.p,
                     m_axis_tdata[106:75]);
            fails = fails + 1;
          end
        end
      end
    end
    pending <= reply_q.size();
  end

endmodule

[tb/tb_indexed_min_heap_unit.sv]
`timescale 1ns / 1ps

module tb_indexed_min_heap_unit;

  localparam logic [2:0] REQ_UNUSED = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [6:0]   cfg_data = 7'd0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  int           fails;
  int           pending;
  bit           no_gaps = 1'b0;
  int           sink_wait = 0;
  int           sent = 0;
  logic [7:0]   issued = 8'd0;

  always #2 clk = ~clk;

  indexed_min_heap_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  imh_heap_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .fails(fails), .pending(pending)
  );

  // result side: draw a stall after each beat
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sink_wait = no_gaps ? 0 : $urandom_range(0, 11);
      else if (sink_wait > 0) sink_wait = sink_wait - 1;
      m_axis_tready <= (sink_wait == 0);
    end
  end

  task automatic send(logic [2:0] req, logic [63:0] key, logic [31:0] pay, logic [7:0] hid);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, hid, pay, key, req};
    do @(posedge clk); while (!s_axis_tready);
    sent = sent + 1;
    if (req == imh_pkg::REQ_INSERT) issued = issued + 8'd1;
    if (req == imh_pkg::REQ_CLEAR) issued = 8'd0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_limit(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 64'($urandom_range(0, 15));
    if (r < 8) return {$urandom, $urandom};
    return (r == 8) ? 64'd0 : {64{1'b1}};
  endfunction

  task automatic random_req(bit heavy);
    int          r;
    logic [2:0]  req;
    logic [7:0]  hid;
    r = $urandom_range(0, 99);
    if (r < (heavy ? 55 : 40)) req = imh_pkg::REQ_INSERT;
    else if (r < 62) req = imh_pkg::REQ_EXTRACT;
    else if (r < 68) req = imh_pkg::REQ_READ;
    else if (r < 78) req = imh_pkg::REQ_UPDATE;
    else if (r < 86) req = imh_pkg::REQ_DELETE;
    else if (r < 93) req = imh_pkg::REQ_GET_KEY;
    else if (r < 95 && !heavy) req = imh_pkg::REQ_CLEAR;
    else if (r < 96) req = REQ_UNUSED;
    else req = imh_pkg::REQ_INSERT;
    hid = ($urandom_range(0, 9) == 0) ? 8'($urandom) : issued - 8'($urandom_range(1, 40));
    send(req, pick_key(), $urandom, hid);
  endtask

  task automatic random_run(int n, bit heavy);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) no_gaps = ~no_gaps;
      random_req(heavy);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    #3000000;
    $display("indexed_min_heap_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: key and payload extremes, ties, errors on empty and unknown handles
    send(imh_pkg::REQ_INSERT, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_INSERT, {64{1'b1}}, {32{1'b1}}, 8'hff);
    send(imh_pkg::REQ_INSERT, 64'd5, 32'h1234_5678, 8'd0);
    send(imh_pkg::REQ_READ, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_GET_KEY, 64'd0, 32'd0, 8'd1);
    send(imh_pkg::REQ_UPDATE, 64'd0, 32'd0, 8'd2);
    send(imh_pkg::REQ_UPDATE, {64{1'b1}}, 32'd0, 8'd0);
    send(imh_pkg::REQ_DELETE, 64'd0, 32'd0, 8'd1);
    send(imh_pkg::REQ_DELETE, 64'd0, 32'd0, 8'd200);
    send(imh_pkg::REQ_GET_KEY, 64'd0, 32'd0, 8'hff);
    send(imh_pkg::REQ_UPDATE, 64'd9, 32'd0, 8'd99);
    send(REQ_UNUSED, {64{1'b1}}, {32{1'b1}}, 8'hff);
    send(imh_pkg::REQ_EXTRACT, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_EXTRACT, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_EXTRACT, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_READ, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_DELETE, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_GET_KEY, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_INSERT, 64'd7, 32'd7, 8'd0);
    send(imh_pkg::REQ_CLEAR, 64'd0, 32'd0, 8'd0);
    send(imh_pkg::REQ_INSERT, 64'd3, 32'd3, 8'd0);
    random_run(130, 1'b0);
    set_limit(7'd127);
    random_run(130, 1'b0);
    set_limit(7'd3);
    random_run(100, 1'b0);
    set_limit(7'd0);
    random_run(30, 1'b0);
    set_limit(7'd1);
    random_run(60, 1'b0);
    // no clears here so the handle counter wraps onto live handles
    set_limit(7'd64);
    random_run(400, 1'b1);
    set_limit(7'($urandom_range(2, 63)));
    random_run(100, 1'b0);
    drain();
    $display("sent %0d requests over capacity limits 64, 127, 3, 0, 1 and random;", sent);
    $display("handle wrap with live handles exercised in a long run without clears");
    if (fails == 0) $display("indexed_min_heap_unit: match");
    else $display("indexed_min_heap_unit: mismatch");
    $finish;
  end

endmodule
